[sv/pmt_pkg.sv]
// ----------------------------------------------------------------------------
// pmt_pkg
// Shared types and constants for the PMT section parser: beat layouts,
// record kinds and parse phases.
// ----------------------------------------------------------------------------
package pmt_pkg;

    // fixed section layout
    localparam int MIN_SECTION_LENGTH = 13;
    localparam int HEADER_BYTES       = 12;
    localparam int ENTRY_BYTES        = 5;
    localparam int CRC_BYTES          = 4;

    // kind of record carried by an output beat
    typedef enum logic [1:0] {
        KIND_HEADER = 2'd0,
        KIND_STREAM = 2'd1,
        KIND_END    = 2'd2,
        KIND_ERROR  = 2'd3
    } t_record_kind;

    // parse phase of the section walker
    typedef enum logic [2:0] {
        PH_IDLE      = 3'd0,
        PH_HEADER    = 3'd1,
        PH_PDESC     = 3'd2,
        PH_ENTRY     = 3'd3,
        PH_ESDESC    = 3'd4,
        PH_CRC_FIRST = 3'd5,
        PH_CRC_REST  = 3'd6
    } t_phase;

    // one section byte with its framing marks
    typedef struct packed {
        logic [7:0] data_byte;
        logic       start_of_section;
        logic       last_byte;
    } t_in_beat;

    // one parsed record
    typedef struct packed {
        t_record_kind record_kind;
        logic [7:0]   tbl_id;
        logic [11:0]  sect_len;
        logic [15:0]  prog_num;
        logic [4:0]   ver_num;
        logic         cur_next;
        logic [7:0]   sect_num;
        logic [7:0]   last_sect_num;
        logic [12:0]  pcr_pid;
        logic [11:0]  info_length;
        logic [7:0]   strm_type;
        logic [12:0]  es_pid;
    } t_out_beat;

endpackage

[sv/pmt_parse_core.sv]
// ----------------------------------------------------------------------------
// pmt_parse_core
// Section walker: holds the parse state and header fields, and for each
// accepted byte works out the next state and at most one record.
// ----------------------------------------------------------------------------
module pmt_parse_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_accept,
    input  pmt_pkg::t_in_beat  i_beat,
    output logic               o_res_valid,
    output pmt_pkg::t_out_beat o_res
);

    // parse state
    pmt_pkg::t_phase r_phase, n_phase;
    logic [11:0]     r_pos, n_pos;
    logic [11:0]     r_skip, n_skip;
    logic [2:0]      r_idx, n_idx;

    // held fields
    logic [11:0] r_sec_len, n_sec_len;
    logic [7:0]  r_table_id, n_table_id;
    logic [15:0] r_prog_num, n_prog_num;
    logic [5:0]  r_ver_flags, n_ver_flags;
    logic [15:0] r_sec_nums, n_sec_nums;
    logic [12:0] r_pcr_pid, n_pcr_pid;
    logic [7:0]  r_stream_type, n_stream_type;
    logic [12:0] r_es_pid, n_es_pid;

    // per-beat working values
    pmt_pkg::t_phase       v_before;
    pmt_pkg::t_record_kind v_kind;
    logic                  v_emit;
    logic [11:0]           v_pos;
    logic [11:0]           v_end;
    logic [11:0]           v_len;
    logic [12:0]           v_next;
    logic [11:0]           v_info;
    logic [7:0]            v_st;
    logic [12:0]           v_pid;
    logic [7:0]            b;

    // next state and record for the current beat
    always_comb begin
        n_phase       = r_phase;
        n_pos         = r_pos;
        n_skip        = r_skip;
        n_idx         = r_idx;
        n_sec_len     = r_sec_len;
        n_table_id    = r_table_id;
        n_prog_num    = r_prog_num;
        n_ver_flags   = r_ver_flags;
        n_sec_nums    = r_sec_nums;
        n_pcr_pid     = r_pcr_pid;
        n_stream_type = r_stream_type;
        n_es_pid      = r_es_pid;
        v_emit        = 1'b0;
        v_kind        = pmt_pkg::KIND_HEADER;
        v_info        = '0;
        v_st          = '0;
        v_pid         = '0;
        v_before      = pmt_pkg::PH_IDLE;
        v_pos         = '0;
        v_end         = '0;
        v_len         = '0;
        v_next        = '0;
        b             = i_beat.data_byte;

        if (i_accept && (i_beat.start_of_section || r_phase != pmt_pkg::PH_IDLE)) begin
            // a start mark drops any parse in progress
            if (i_beat.start_of_section) begin
                n_phase       = pmt_pkg::PH_HEADER;
                n_pos         = '0;
                n_skip        = '0;
                n_idx         = '0;
                n_sec_len     = '0;
                n_table_id    = '0;
                n_prog_num    = '0;
                n_ver_flags   = '0;
                n_sec_nums    = '0;
                n_pcr_pid     = '0;
                n_stream_type = '0;
                n_es_pid      = '0;
            end
            v_before = n_phase;
            v_pos    = n_pos;
            v_end    = (n_sec_len != '0) ? n_sec_len - 12'd1 : 12'd0;
            v_next   = {1'b0, v_pos} + 13'd1;

            unique case (v_before)
                pmt_pkg::PH_HEADER: begin
                    // fixed header fields
                    case (v_pos)
                        12'd0:  n_table_id = b;
                        12'd1:  n_sec_len = {b[3:0], 8'h00};
                        12'd2:  n_sec_len = n_sec_len | {4'h0, b};
                        12'd3:  n_prog_num = {b, 8'h00};
                        12'd4:  n_prog_num = n_prog_num | {8'h00, b};
                        12'd5:  n_ver_flags = b[5:0];
                        12'd6:  n_sec_nums = {b, 8'h00};
                        12'd7:  n_sec_nums = n_sec_nums | {8'h00, b};
                        12'd8:  n_pcr_pid = {b[4:0], 8'h00};
                        12'd9:  n_pcr_pid = n_pcr_pid | {5'h00, b};
                        12'd10: n_skip = {b[3:0], 8'h00};
                        default: ;
                    endcase
                    if (v_pos >= 12'(pmt_pkg::HEADER_BYTES - 1)) begin
                        v_len  = n_skip | {4'h0, b};
                        v_emit = 1'b1;
                        if (n_sec_len < 12'(pmt_pkg::MIN_SECTION_LENGTH) ||
                            13'(pmt_pkg::HEADER_BYTES) + {1'b0, v_len} > {1'b0, v_end}) begin
                            v_kind  = pmt_pkg::KIND_ERROR;
                            n_phase = pmt_pkg::PH_IDLE;
                        end else begin
                            v_kind = pmt_pkg::KIND_HEADER;
                            v_info = v_len;
                            if (v_len != '0) begin
                                n_skip  = v_len;
                                n_phase = pmt_pkg::PH_PDESC;
                                n_pos   = 12'(pmt_pkg::HEADER_BYTES);
                            end else begin
                                n_pos   = 12'(pmt_pkg::HEADER_BYTES);
                                n_idx   = '0;
                                n_phase = (12'(pmt_pkg::HEADER_BYTES) == v_end) ?
                                          pmt_pkg::PH_CRC_FIRST : pmt_pkg::PH_ENTRY;
                            end
                        end
                    end else begin
                        n_pos = v_next[11:0];
                    end
                end
                pmt_pkg::PH_PDESC, pmt_pkg::PH_ESDESC: begin
                    // descriptor skip
                    n_skip = n_skip - 12'd1;
                    n_pos  = v_next[11:0];
                    if (n_skip == '0) begin
                        n_idx   = '0;
                        n_phase = (v_next == {1'b0, v_end}) ?
                                  pmt_pkg::PH_CRC_FIRST : pmt_pkg::PH_ENTRY;
                    end
                end
                pmt_pkg::PH_ENTRY: begin
                    // five-byte stream entry
                    if (n_idx == 3'd0 &&
                        {1'b0, v_pos} + 13'(pmt_pkg::ENTRY_BYTES) > {1'b0, v_end}) begin
                        v_emit  = 1'b1;
                        v_kind  = pmt_pkg::KIND_ERROR;
                        n_phase = pmt_pkg::PH_IDLE;
                    end else if (n_idx <= 3'd3) begin
                        case (n_idx)
                            3'd0:    n_stream_type = b;
                            3'd1:    n_es_pid = {b[4:0], 8'h00};
                            3'd2:    n_es_pid = n_es_pid | {5'h00, b};
                            default: n_skip = {b[3:0], 8'h00};
                        endcase
                        n_idx = n_idx + 3'd1;
                        n_pos = v_next[11:0];
                    end else begin
                        v_len  = n_skip | {4'h0, b};
                        v_emit = 1'b1;
                        if (v_next + {1'b0, v_len} > {1'b0, v_end}) begin
                            v_kind  = pmt_pkg::KIND_ERROR;
                            n_phase = pmt_pkg::PH_IDLE;
                        end else begin
                            v_kind = pmt_pkg::KIND_STREAM;
                            v_info = v_len;
                            v_st   = n_stream_type;
                            v_pid  = n_es_pid;
                            n_pos  = v_next[11:0];
                            if (v_len != '0) begin
                                n_skip  = v_len;
                                n_phase = pmt_pkg::PH_ESDESC;
                            end else begin
                                n_idx   = '0;
                                n_phase = (v_next == {1'b0, v_end}) ?
                                          pmt_pkg::PH_CRC_FIRST : pmt_pkg::PH_ENTRY;
                            end
                        end
                    end
                end
                pmt_pkg::PH_CRC_FIRST: begin
                    // end record on the first CRC byte
                    v_emit  = 1'b1;
                    v_kind  = pmt_pkg::KIND_END;
                    n_skip  = 12'(pmt_pkg::CRC_BYTES - 1);
                    n_phase = pmt_pkg::PH_CRC_REST;
                end
                pmt_pkg::PH_CRC_REST: begin
                    n_skip = n_skip - 12'd1;
                    if (n_skip == '0) begin
                        n_phase = pmt_pkg::PH_IDLE;
                    end
                end
                default: begin
                    n_phase = pmt_pkg::PH_IDLE;
                end
            endcase

            // buffer end before the CRC is a truncated section
            if (i_beat.last_byte) begin
                if (v_before inside {pmt_pkg::PH_HEADER, pmt_pkg::PH_PDESC,
                                     pmt_pkg::PH_ENTRY, pmt_pkg::PH_ESDESC}) begin
                    v_emit = 1'b1;
                    v_kind = pmt_pkg::KIND_ERROR;
                end
                n_phase = pmt_pkg::PH_IDLE;
            end

            if (v_kind == pmt_pkg::KIND_ERROR) begin
                v_info = '0;
                v_st   = '0;
                v_pid  = '0;
            end
        end
    end

    // record assembly from the updated held fields
    always_comb begin
        o_res_valid         = v_emit;
        o_res.record_kind   = v_kind;
        o_res.tbl_id        = n_table_id;
        o_res.sect_len      = n_sec_len;
        o_res.prog_num      = n_prog_num;
        o_res.ver_num       = n_ver_flags[5:1];
        o_res.cur_next      = n_ver_flags[0];
        o_res.sect_num      = n_sec_nums[15:8];
        o_res.last_sect_num = n_sec_nums[7:0];
        o_res.pcr_pid       = n_pcr_pid;
        o_res.info_length   = v_info;
        o_res.strm_type     = v_st;
        o_res.es_pid        = v_pid;
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= pmt_pkg::PH_IDLE;
            r_pos         <= '0;
            r_skip        <= '0;
            r_idx         <= '0;
            r_sec_len     <= '0;
            r_table_id    <= '0;
            r_prog_num    <= '0;
            r_ver_flags   <= '0;
            r_sec_nums    <= '0;
            r_pcr_pid     <= '0;
            r_stream_type <= '0;
            r_es_pid      <= '0;
        end else begin
            r_phase       <= n_phase;
            r_pos         <= n_pos;
            r_skip        <= n_skip;
            r_idx         <= n_idx;
            r_sec_len     <= n_sec_len;
            r_table_id    <= n_table_id;
            r_prog_num    <= n_prog_num;
            r_ver_flags   <= n_ver_flags;
            r_sec_nums    <= n_sec_nums;
            r_pcr_pid     <= n_pcr_pid;
            r_stream_type <= n_stream_type;
            r_es_pid      <= n_es_pid;
        end
    end

endmodule

[sv/pmt_section_parser.sv]
// ----------------------------------------------------------------------------
// pmt_section_parser
// Program map table section parser: one section byte per input beat,
// header, stream entry, section end and error records on the output.
// ----------------------------------------------------------------------------
// Usage
//   Input channel: one section byte per beat, start_of_section on the table
//   id byte, last_byte on the final byte of the supplied buffer. Bytes that
//   arrive outside a section are dropped without a record.
//   Output channel: at most one record per input beat, in byte order.
//   Records: each record is registered in the output register, through the
//   skid stage while the receiver stalls, and shown on o_out_valid from it.
//   Throughput: one byte per cycle while o_in_stall is low; each byte passes
//   through a single combinational field update between the parse state
//   and the output register.
//   Stall: while the receiver stalls, the output register holds its record
//   and a one-record skid stage takes the next record; the input stalls only
//   while that skid stage is full.
//   Reset: synchronous, active low; clears the parse state to idle and
//   empties the output and skid stages.
// ----------------------------------------------------------------------------
module pmt_section_parser (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  pmt_pkg::t_in_beat  i_in,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output pmt_pkg::t_out_beat o_out
);

    logic               accept;
    logic               res_valid;
    pmt_pkg::t_out_beat res;
    logic               out_free;

    logic               r_out_valid;
    pmt_pkg::t_out_beat r_out;
    logic               r_skid_valid;
    pmt_pkg::t_out_beat r_skid;

    // input handshake
    assign o_in_stall = r_skid_valid;
    assign accept     = i_in_valid && !r_skid_valid;

    // section walker
    pmt_parse_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_beat      (i_in),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    // output register slot is free when empty or being taken
    assign out_free = !r_out_valid || !i_out_stall;

    // output register and skid stage control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_free) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid  <= accept && res_valid;
            end
        end else if (accept && res_valid) begin
            r_skid_valid <= 1'b1;
        end
    end

    // output and skid payload
    always_ff @(posedge i_clk) begin
        if (out_free) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else if (accept && res_valid) begin
                r_out <= res;
            end
        end else if (accept && res_valid) begin
            r_skid <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule
